>>> src/mtbt_pkg.sv
// Shared types, constants and the accent lookup for the beat tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package mtbt_pkg;

    localparam int POS_BITS  = 48;          // frame position width
    localparam int MAX_BPB   = 32;          // largest numerator
    localparam int LW        = 56;          // beat length, Q.16 frames
    localparam int RW        = 56;          // divider remainder / divisor width
    localparam int DVW       = 65;          // divider dividend shift width
    localparam int QW        = 64;          // divider quotient width
    localparam int CW        = 7;           // divider step counter width
    localparam int SRW       = 19;          // sample_rate width
    localparam int TPW       = 18;          // tempo width
    localparam int BPBW      = 6;           // beats_per_bar width
    localparam int BNDW      = 49;          // next_boundary width

    localparam logic [SRW-1:0]  SR_RESET    = 19'd48000;
    localparam logic [TPW-1:0]  TEMPO_RESET = 18'd30720;
    localparam logic [BPBW-1:0] BPB_RESET   = 6'd4;
    localparam logic [LW-1:0]   LEN_RESET   = 56'd1572864000;

    localparam logic [1:0] CMD_ADVANCE = 2'd0;
    localparam logic [1:0] CMD_SET     = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] CFG_TEMPO       = 2'd1;
    localparam logic [1:0] CFG_BPB         = 2'd2;
    localparam logic [1:0] CFG_EIGHTH      = 2'd3;

    localparam logic [1:0] GRID_OFF  = 2'd0;
    localparam logic [1:0] GRID_BEAT = 2'd1;
    localparam logic [1:0] GRID_HALF = 2'd2;
    localparam logic [1:0] GRID_BAR  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LSTART,
        S_LCALC,
        S_DBAR,
        S_DBEAT,
        S_DPHASE,
        S_DBND,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_LEN,
        OP_BAR,
        OP_BEAT,
        OP_PHASE,
        OP_BND
    } div_op_t;

    typedef struct packed {
        logic    accept;
        logic    start;
        div_op_t start_op;
        logic    store;
        div_op_t store_op;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } dp_sts_t;

    // bit b set: beat b opens a group in the x/8 groupings
    function automatic logic [31:0] group_starts(input logic [BPBW-1:0] bpb);
        logic [31:0] g;
        unique case (bpb)
            6'd5:    g = 32'h0000_0005;
            6'd6:    g = 32'h0000_0009;
            6'd7:    g = 32'h0000_0015;
            6'd9:    g = 32'h0000_0049;
            6'd12:   g = 32'h0000_0249;
            default: g = 32'h0000_0000;
        endcase
        return g;
    endfunction

    function automatic logic is_accent(input logic [4:0] beat,
                                       input logic [BPBW-1:0] bpb,
                                       input logic eighth);
        logic [31:0] g;
        g = group_starts(bpb);
        return (beat == 5'd0) || (eighth && g[beat]);
    endfunction

endpackage

`default_nettype wire

>>> src/mtbt_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on mtbt_pkg.
`default_nettype none

module mtbt_div (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [mtbt_pkg::DVW-1:0] dvd_in,
    input  wire logic [mtbt_pkg::RW-1:0]  rem_in,
    input  wire logic [mtbt_pkg::RW-1:0]  dsr_in,
    input  wire logic [mtbt_pkg::CW-1:0]  steps_in,
    output logic                          busy,
    output logic [mtbt_pkg::QW-1:0]       quo,
    output logic [mtbt_pkg::RW-1:0]       rem
);
    import mtbt_pkg::*;

    logic [DVW-1:0] dvd_reg;
    logic [RW-1:0]  rem_reg;
    logic [RW-1:0]  dsr_reg;
    logic [QW-1:0]  quo_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [RW:0]    trial;
    logic [RW:0]    diff;
    logic           ge;

    assign trial = {rem_reg, dvd_reg[DVW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        if (start)
            cnt_next = steps_in;
        else if (cnt_reg != '0)
            cnt_next = cnt_reg - 1'b1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dvd_in;
            rem_reg <= rem_in;
            dsr_reg <= dsr_in;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[RW-1:0] : trial[RW-1:0];
            dvd_reg <= {dvd_reg[DVW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> src/mtbt_dp.sv
// Datapath: config registers, position, beat length, divider and result registers.
// Depends on mtbt_pkg and mtbt_div.
`default_nettype none

module mtbt_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [mtbt_pkg::SRW-1:0]  cfg_data,
    input  wire logic [1:0]                command,
    input  wire logic [mtbt_pkg::POS_BITS-1:0] frames,
    input  wire logic                      playing,
    input  wire logic [mtbt_pkg::POS_BITS-1:0] query_from,
    input  wire logic [1:0]                grid,
    input  wire logic [4:0]                query_beat,
    input  wire mtbt_pkg::ctrl_cmd_t       cmd,
    output mtbt_pkg::dp_sts_t              sts,
    input  wire logic                      m_tready,
    output logic                           m_tvalid,
    output logic [47:0]                    bar_index,
    output logic [4:0]                     beat_in_bar,
    output logic [15:0]                    beat_phase,
    output logic                           accent_now,
    output logic                           query_accent,
    output logic [mtbt_pkg::BNDW-1:0]      next_boundary
);
    import mtbt_pkg::*;

    logic [SRW-1:0]      sr_reg;
    logic [TPW-1:0]      tempo_reg;
    logic [BPBW-1:0]     bpb_reg;
    logic                eighth_reg;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [LW-1:0]       len_reg;
    logic [RW-1:0]       bar_len;
    logic [LW+BPBW-1:0]  bar_prod;
    logic [POS_BITS-1:0] from_reg;
    logic [1:0]          grid_reg;
    logic [4:0]          qbeat_reg;
    logic [47:0]         bar_idx_reg;
    logic [4:0]          beat_reg;
    logic [15:0]         phase_reg;
    logic [RW-1:0]       extra_reg;
    logic                m_tvalid_reg;
    logic [47:0]         o_bar_reg;
    logic [4:0]          o_beat_reg;
    logic [15:0]         o_phase_reg;
    logic                o_acc_reg;
    logic                o_qacc_reg;
    logic [BNDW-1:0]     o_bnd_reg;

    logic [BPBW-1:0]     bpb_wr;
    logic [24:0]         sr60;
    logic [48:0]         num;
    logic [TPW:0]        den;
    logic [RW-1:0]       unit;
    logic [RW:0]         rnd;
    logic [BNDW-1:0]     bnd;
    logic [4:0]          beat_q;
    logic [4:0]          beat_max;

    logic                div_busy;
    logic [QW-1:0]       div_quo;
    logic [RW-1:0]       div_rem;
    logic [DVW-1:0]      dvd_in;
    logic [RW-1:0]       rem_in;
    logic [RW-1:0]       dsr_in;
    logic [CW-1:0]       steps_in;

    // numerator write: zero becomes one, saturate at the maximum
    always_comb
    begin
        if (cfg_data[BPBW-1:0] == '0)
            bpb_wr = BPBW'(1);
        else if (cfg_data[BPBW-1:0] > BPBW'(MAX_BPB))
            bpb_wr = BPBW'(MAX_BPB);
        else
            bpb_wr = cfg_data[BPBW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg     <= SR_RESET;
            tempo_reg  <= TEMPO_RESET;
            bpb_reg    <= BPB_RESET;
            eighth_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_RATE: if (cfg_data != '0) sr_reg <= cfg_data;
                CFG_TEMPO:       if (cfg_data[TPW-1:0] != '0) tempo_reg <= cfg_data[TPW-1:0];
                CFG_BPB:         bpb_reg <= bpb_wr;
                CFG_EIGHTH:      eighth_reg <= cfg_data[0];
            endcase
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.accept)
        begin
            unique case (command)
                CMD_ADVANCE: pos_next = playing ? pos_reg + frames : pos_reg;
                CMD_SET:     pos_next = frames;
                CMD_CLEAR:   pos_next = '0;
                default:     pos_next = pos_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= LEN_RESET;
        end
        else
        begin
            pos_reg <= pos_next;
            if (cmd.store && cmd.store_op == OP_LEN)
                len_reg <= div_quo[LW-1:0];
        end
    end

    // bar length follows beat length and numerator in the same cycle
    assign bar_prod = {{BPBW{1'b0}}, len_reg} * {{LW{1'b0}}, bpb_reg};
    assign bar_len  = bar_prod[RW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            from_reg  <= query_from;
            grid_reg  <= grid;
            qbeat_reg <= query_beat;
        end
    end

    assign sr60 = {6'b0, sr_reg} * 25'd60;
    assign num  = {sr60, 24'b0};
    assign den  = eighth_reg ? {tempo_reg, 1'b0} : {1'b0, tempo_reg};

    // grid unit in Q.17 frames
    always_comb
    begin
        unique case (grid_reg)
            GRID_HALF: unit = bar_len;
            GRID_BAR:  unit = {bar_len[RW-2:0], 1'b0};
            default:   unit = {len_reg[RW-2:0], 1'b0};
        endcase
    end

    always_comb
    begin
        unique case (cmd.start_op)
            OP_LEN:
            begin
                dvd_in   = {num, 16'b0};
                rem_in   = '0;
                dsr_in   = {{(RW-TPW-1){1'b0}}, den};
                steps_in = CW'(49);
            end
            OP_BAR:
            begin
                dvd_in   = {pos_next, 17'b0};
                rem_in   = '0;
                dsr_in   = bar_len;
                steps_in = CW'(64);
            end
            OP_BEAT:
            begin
                dvd_in   = {div_rem[4:0], {(DVW-5){1'b0}}};
                rem_in   = {5'b0, div_rem[RW-1:5]};
                dsr_in   = len_reg;
                steps_in = CW'(5);
            end
            OP_PHASE:
            begin
                dvd_in   = '0;
                rem_in   = div_rem;
                dsr_in   = len_reg;
                steps_in = CW'(16);
            end
            OP_BND:
            begin
                dvd_in   = {from_reg, 17'b0};
                rem_in   = '0;
                dsr_in   = unit;
                steps_in = CW'(65);
            end
            default:
            begin
                dvd_in   = '0;
                rem_in   = '0;
                dsr_in   = len_reg;
                steps_in = CW'(1);
            end
        endcase
    end

    mtbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .dvd_in   (dvd_in),
        .rem_in   (rem_in),
        .dsr_in   (dsr_in),
        .steps_in (steps_in),
        .busy     (div_busy),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    assign beat_max = 5'(bpb_reg - 1'b1);
    assign beat_q   = (div_quo[4:0] > beat_max) ? beat_max : div_quo[4:0];

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            unique case (cmd.store_op)
                OP_BAR:   bar_idx_reg <= div_quo[47:0];
                OP_BEAT:  beat_reg    <= beat_q;
                OP_PHASE: phase_reg   <= div_quo[15:0];
                OP_BND:   extra_reg   <= (div_rem != '0) ? unit - div_rem : '0;
                default:  ;
            endcase
        end
    end

    // round extra Q.17 to whole frames, ties up
    assign rnd = {1'b0, extra_reg} + (RW+1)'(17'h10000);
    assign bnd = (grid_reg == GRID_OFF) ? {1'b0, from_reg}
                                        : {1'b0, from_reg} + BNDW'(rnd[RW:17]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_bar_reg   <= bar_idx_reg;
            o_beat_reg  <= beat_reg;
            o_phase_reg <= phase_reg;
            o_acc_reg   <= is_accent(beat_reg, bpb_reg, eighth_reg);
            o_qacc_reg  <= is_accent(qbeat_reg, bpb_reg, eighth_reg);
            o_bnd_reg   <= bnd;
        end
    end

    assign sts.div_busy  = div_busy;
    assign sts.out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign bar_index     = o_bar_reg;
    assign beat_in_bar   = o_beat_reg;
    assign beat_phase    = o_phase_reg;
    assign accent_now    = o_acc_reg;
    assign query_accent  = o_qacc_reg;
    assign next_boundary = o_bnd_reg;

endmodule

`default_nettype wire

>>> src/mtbt_ctrl.sv
// Controller: sequences beat-length recompute and the four divisions per word.
// Depends on mtbt_pkg.
`default_nettype none

module mtbt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                cfg_we,
    input  wire mtbt_pkg::dp_sts_t   sts,
    output logic                     s_tready,
    output mtbt_pkg::ctrl_cmd_t      cmd
);
    import mtbt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.start    = 1'b0;
        cmd.start_op = OP_LEN;
        cmd.store    = 1'b0;
        cmd.store_op = OP_LEN;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = !cfg_we;
                if (cfg_we)
                    state_next = S_LSTART;
                else if (s_tvalid)
                begin
                    cmd.accept   = 1'b1;
                    cmd.start    = 1'b1;
                    cmd.start_op = OP_BAR;
                    state_next   = S_DBAR;
                end
            end
            S_LSTART:
            begin
                if (!cfg_we)
                begin
                    cmd.start    = 1'b1;
                    cmd.start_op = OP_LEN;
                    state_next   = S_LCALC;
                end
            end
            S_LCALC:
            begin
                if (cfg_we)
                    state_next = S_LSTART;
                else if (!sts.div_busy)
                begin
                    cmd.store    = 1'b1;
                    cmd.store_op = OP_LEN;
                    state_next   = S_IDLE;
                end
            end
            S_DBAR:
            begin
                if (!sts.div_busy)
                begin
                    cmd.store    = 1'b1;
                    cmd.store_op = OP_BAR;
                    cmd.start    = 1'b1;
                    cmd.start_op = OP_BEAT;
                    state_next   = S_DBEAT;
                end
            end
            S_DBEAT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.store    = 1'b1;
                    cmd.store_op = OP_BEAT;
                    cmd.start    = 1'b1;
                    cmd.start_op = OP_PHASE;
                    state_next   = S_DPHASE;
                end
            end
            S_DPHASE:
            begin
                if (!sts.div_busy)
                begin
                    cmd.store    = 1'b1;
                    cmd.store_op = OP_PHASE;
                    cmd.start    = 1'b1;
                    cmd.start_op = OP_BND;
                    state_next   = S_DBND;
                end
            end
            S_DBND:
            begin
                if (!sts.div_busy)
                begin
                    cmd.store    = 1'b1;
                    cmd.store_op = OP_BND;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> sts.div_busy)
        else $error("divider not busy after start");

    a_accept_bar: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_DBAR))
        else $error("accepted word did not start bar division");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending word");

    a_store_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !sts.div_busy)
        else $error("result stored while divider running");

endmodule

`default_nettype wire

>>> src/musical_transport_beat_tracker.sv
// Top level of the musical transport beat tracker.
// Depends on mtbt_pkg, mtbt_ctrl, mtbt_dp (which holds mtbt_div).
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  s_*     | s_tvalid/s_tready  | tdata: frames, playing, query_from, grid,
//          |                    |        query_beat; tuser: command
//  m_*     | m_tvalid/m_tready  | tdata: bar_index, beat_in_bar, beat_phase,
//          |                    |        accent_now, query_accent, next_boundary
//  cfg_*   | cfg_we             | cfg_index, cfg_data (no read-back)
//
// Per accepted word, a 64-step bar, 5-step beat, 16-step phase and 65-step
// boundary division run in turn on one serial divider, each result stored as
// its division ends, then the output load. The next word is taken in S_IDLE
// after the load unless cfg_we is high. A config write seen while idle or
// recomputing reruns the 49-step beat-length division; s_tready stays low
// until it ends. A finished result sits in the output register; the next word
// is taken meanwhile and waits in its last step if the register is still full.
// Reset restores the default tempo setup and clears the position.
`default_nettype none

module musical_transport_beat_tracker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // config write port
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [18:0]  cfg_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [47:0] frames, [48] playing, [96:49] query_from, [98:97] grid,
    // [103:99] query_beat
    input  wire logic [103:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]   s_tuser,
    // output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [47:0] bar_index, [52:48] beat_in_bar, [68:53] beat_phase,
    // [69] accent_now, [70] query_accent, [119:71] next_boundary
    output logic [119:0]      m_tdata
);
    import mtbt_pkg::*;

    ctrl_cmd_t       cmd;
    dp_sts_t         sts;
    logic [47:0]     bar_index;
    logic [4:0]      beat_in_bar;
    logic [15:0]     beat_phase;
    logic            accent_now;
    logic            query_accent;
    logic [BNDW-1:0] next_boundary;

    mtbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .cfg_we   (cfg_we),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    mtbt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (s_tuser),
        .frames        (s_tdata[47:0]),
        .playing       (s_tdata[48]),
        .query_from    (s_tdata[96:49]),
        .grid          (s_tdata[98:97]),
        .query_beat    (s_tdata[103:99]),
        .cmd           (cmd),
        .sts           (sts),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .bar_index     (bar_index),
        .beat_in_bar   (beat_in_bar),
        .beat_phase    (beat_phase),
        .accent_now    (accent_now),
        .query_accent  (query_accent),
        .next_boundary (next_boundary)
    );

    assign m_tdata = {next_boundary, query_accent, accent_now,
                      beat_phase, beat_in_bar, bar_index};

endmodule

`default_nettype wire

>>> tb/musical_transport_beat_tracker_chk.sv
// Scoreboard for the beat tracker: mirrors config writes, predicts each result word
// from every accepted input word, and compares the output stream against it.
// Depends on mtbt_pkg for the command, grid and config index codes.
`default_nettype none

module musical_transport_beat_tracker_chk
    import mtbt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [18:0]  cfg_data,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [103:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [119:0] m_tdata,
    output int                fails,
    output int                pending,
    output int                checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [48:0] boundary;
        logic        q_accent;
        logic        accent;
        logic [15:0] phase;
        logic [4:0]  beat;
        logic [47:0] bar_idx;
    } beat_info_t;

    beat_info_t expected_beats[$];

    logic [63:0] rate, tempo, bpb, eighth, beat_len;
    logic [47:0] pos;

    // floor(a * 2^sh / d) and the remainder, both kept to 64 bits
    function automatic void shifted_div(input logic [63:0] a, input logic [63:0] d,
                                        input int sh, output logic [63:0] q,
                                        output logic [63:0] r);
        logic [127:0] n;
        n = {64'd0, a} << sh;
        q = 64'(n / {64'd0, d});
        r = 64'(n % {64'd0, d});
    endfunction

    function automatic logic [63:0] calc_len(input logic [63:0] sr, input logic [63:0] tp,
                                             input logic [63:0] e8);
        return ((sr * 64'd60) << 24) / (tp << e8[0]);
    endfunction

    function automatic logic accented(input logic [63:0] b, input logic [63:0] num,
                                      input logic [63:0] e8);
        logic [31:0] starts;
        case (num)
            64'd5:   starts = 32'h005;
            64'd6:   starts = 32'h009;
            64'd7:   starts = 32'h015;
            64'd9:   starts = 32'h049;
            64'd12:  starts = 32'h249;
            default: starts = 32'h0;
        endcase
        if (b == 0) return 1'b1;
        if (!e8[0] || b >= 32) return 1'b0;
        return starts[b[4:0]];
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    assign pending = expected_beats.size();

    always @(posedge clk or negedge rst_n) begin
        logic [63:0] barlen, q, rb, rbeat, ph, dummy, b, unit, r, extra, bnd;
        logic [63:0] new_pos;
        beat_info_t e, act;
        if (!rst_n) begin
            rate     <= 64'd48000;
            tempo    <= 64'd30720;
            bpb      <= 64'd4;
            eighth   <= 64'd0;
            beat_len <= calc_len(64'd48000, 64'd30720, 64'd0);
            pos      <= '0;
            fails    <= 0;
            checked  <= 0;
            expected_beats.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SAMPLE_RATE:
                        if (cfg_data != 0) begin
                            rate     <= 64'(cfg_data);
                            beat_len <= calc_len(64'(cfg_data), tempo, eighth);
                        end
                    CFG_TEMPO:
                        if (cfg_data[17:0] != 0) begin
                            tempo    <= 64'(cfg_data[17:0]);
                            beat_len <= calc_len(rate, 64'(cfg_data[17:0]), eighth);
                        end
                    CFG_BPB:
                        bpb <= (cfg_data[5:0] == 0) ? 64'd1 :
                               (cfg_data[5:0] > MAX_BPB) ? 64'(MAX_BPB) : 64'(cfg_data[5:0]);
                    default: begin
                        eighth   <= 64'(cfg_data[0]);
                        beat_len <= calc_len(rate, tempo, 64'(cfg_data[0]));
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                new_pos = 64'(pos);
                case (s_tuser)
                    CMD_ADVANCE: if (s_tdata[48]) new_pos = (new_pos + s_tdata[47:0]) & 64'hFFFF_FFFF_FFFF;
                    CMD_SET:     new_pos = 64'(s_tdata[47:0]);
                    CMD_CLEAR:   new_pos = 0;
                    default:     ;   // unused command holds the position
                endcase
                pos <= new_pos[47:0];
                barlen = beat_len * bpb;
                shifted_div(new_pos, barlen, 16, q, rb);
                b = rb / beat_len;
                if (b > bpb - 1) b = bpb - 1;
                shifted_div(new_pos, beat_len, 16, dummy, rbeat);
                shifted_div(rbeat, beat_len, 16, ph, dummy);
                case (s_tdata[98:97])
                    GRID_OFF:  unit = 0;
                    GRID_BEAT: unit = beat_len << 1;
                    GRID_HALF: unit = barlen;
                    default:   unit = barlen << 1;
                endcase
                if (unit == 0) bnd = 64'(s_tdata[96:49]);
                else begin
                    shifted_div(64'(s_tdata[96:49]), unit, 17, dummy, r);
                    extra = (r != 0) ? unit - r : 0;
                    bnd = 64'(s_tdata[96:49]) + ((extra + 64'h1_0000) >> 17);
                end
                e.bar_idx  = q[47:0];
                e.beat     = b[4:0];
                e.phase    = ph[15:0];
                e.accent   = accented(b, bpb, eighth);
                e.q_accent = accented(64'(s_tdata[103:99]), bpb, eighth);
                e.boundary = bnd[48:0];
                expected_beats.push_back(e);
            end
            if (m_tvalid && m_tready) begin
                act = m_tdata;
                if (expected_beats.size() == 0) begin
                    $display("%0t unexpected result word %h", $time, m_tdata);
                    fails++;
                end else begin
                    e = expected_beats.pop_front();
                    check_field("bar_index", 64'(e.bar_idx), 64'(act.bar_idx));
                    check_field("beat_in_bar", 64'(e.beat), 64'(act.beat));
                    check_field("beat_phase", 64'(e.phase), 64'(act.phase));
                    check_field("accent_now", 64'(e.accent), 64'(act.accent));
                    check_field("query_accent", 64'(e.q_accent), 64'(act.q_accent));
                    check_field("next_boundary", 64'(e.boundary), 64'(act.boundary));
                    checked++;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/musical_transport_beat_tracker_tb.sv
// Top of the beat tracker testbench: clock, reset, stimulus and verdict.
// Depends on mtbt_pkg, the block and musical_transport_beat_tracker_chk.
`default_nettype none

module musical_transport_beat_tracker_tb;
    import mtbt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 300;         // > one word plus a config rerun

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [18:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;    // frames, playing, query_from, grid, query_beat
    logic [1:0]   s_tuser = '0;    // command
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;         // bar_index, beat, phase, accents, next_boundary
    int           fails, pending, checked;
    int           cycles = 0;
    int           cfg_writes = 0;
    bit           rx_choppy = 0;
    int           rx_left = 0;

    always #10 clk = ~clk;

    musical_transport_beat_tracker i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    musical_transport_beat_tracker_chk i_chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fails(fails), .pending(pending), .checked(checked)
    );

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: alternates free-running and choppy stretches
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_choppy <= $urandom_range(0, 2) != 0;
            rx_left   <= $urandom_range(20, 600);
            m_tready  <= 1'b1;
        end else begin
            rx_left <= rx_left - 1;
            if (rx_choppy)
                m_tready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 199) != 0 || 1'b0);
            else
                m_tready <= 1'b1;
        end
    end

    // one word; called right after a negedge, returns at the negedge after acceptance
    task automatic send_word(input logic [1:0] cmd, input logic [47:0] frames,
                             input logic play, input logic [47:0] from,
                             input logic [1:0] grid, input logic [4:0] qbeat);
        s_tuser  <= cmd;
        s_tdata  <= {qbeat, grid, from, play, frames};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // only while drained; the tail wait covers a config rerun still in flight
    task automatic write_reg(input logic [1:0] idx, input logic [18:0] val);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [18:0] pick_rate();
        case ($urandom_range(0, 6))
            0: return 19'd1;
            1: return 19'd384000;
            2: return 19'd44100;
            3: return 19'd0;              // ignored
            4: return 19'h7FFFF;
            5: return 19'($urandom_range(1, 384000));
            default: return 19'd48000;
        endcase
    endfunction

    function automatic logic [18:0] pick_tempo();
        case ($urandom_range(0, 6))
            0: return 19'd1;
            1: return 19'd255999;
            2: return 19'd0;              // ignored
            3: return 19'h7FFFF;          // upper bit dropped by the block
            4: return 19'($urandom_range(1, 255999));
            5: return 19'($urandom_range(15000, 50000));
            default: return 19'd30720;
        endcase
    endfunction

    function automatic logic [18:0] pick_bpb();
        case ($urandom_range(0, 9))
            0: return 19'd0;
            1: return 19'd1;
            2: return 19'd32;
            3: return 19'd63;
            4: return 19'd5;
            5: return 19'd6;
            6: return 19'd7;
            7: return 19'd9;
            8: return 19'd12;
            default: return 19'($urandom_range(1, 40));
        endcase
    endfunction

    initial begin
        logic [47:0] fr, qf;
        logic [1:0]  cmd;
        int          burst;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset config, extremes, every command and grid
        send_word(CMD_ADVANCE, 48'd0, 1'b1, 48'd0, GRID_OFF, 5'd0);
        send_word(CMD_ADVANCE, 48'd1000, 1'b1, 48'd1, GRID_BEAT, 5'd31);
        send_word(CMD_ADVANCE, 48'd1000, 1'b0, 48'd24000, GRID_HALF, 5'd1);
        send_word(CMD_SET, 48'hFFFF_FFFF_FFFF, 1'b0, 48'hFFFF_FFFF_FFFF, GRID_BAR, 5'd3);
        send_word(CMD_ADVANCE, 48'd5, 1'b1, 48'hFFFF_FFFF_FFFF, GRID_BEAT, 5'd2);   // wraps
        send_word(2'd3, 48'hFFFF_FFFF_FFFF, 1'b1, 48'd0, GRID_BAR, 5'd0);         // no-op
        send_word(CMD_CLEAR, 48'hFFFF_FFFF_FFFF, 1'b1, 48'd96000, GRID_BAR, 5'd9);
        send_word(CMD_SET, 48'd95999, 1'b1, 48'd95999, GRID_HALF, 5'd6);
        write_reg(CFG_BPB, 19'd12);
        write_reg(CFG_EIGHTH, 19'd1);
        for (int i = 0; i < 12; i++)
            send_word(CMD_SET, 48'(i * 12000), 1'b1, 48'(i * 12000 + 1), GRID_BEAT, 5'(i));
        write_reg(CFG_SAMPLE_RATE, 19'd384000);
        write_reg(CFG_TEMPO, 19'd1);
        send_word(CMD_SET, 48'hFFFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF, GRID_BAR, 5'd31);
        write_reg(CFG_SAMPLE_RATE, 19'd1);
        write_reg(CFG_TEMPO, 19'd255999);
        send_word(CMD_SET, 48'hFFFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFE, GRID_BEAT, 5'd0);

        // random phases, each under a fresh setting
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_SAMPLE_RATE, pick_rate());
            write_reg(CFG_TEMPO, pick_tempo());
            write_reg(CFG_BPB, pick_bpb());
            write_reg(CFG_EIGHTH, 19'($urandom));
            burst = 0;
            for (int n = 0; n < 70; n++) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 12);
                    if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 250));
                end
                burst--;
                case ($urandom_range(0, 19))
                    0, 1:    cmd = CMD_SET;
                    2:       cmd = CMD_CLEAR;
                    3:       cmd = 2'd3;
                    default: cmd = CMD_ADVANCE;
                endcase
                case ($urandom_range(0, 4))
                    0:       fr = {$urandom, $urandom};
                    1:       fr = 48'($urandom_range(0, 1_000_000));
                    default: fr = 48'($urandom_range(0, 2048));
                endcase
                qf = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                                 : 48'($urandom_range(0, 2_000_000));
                send_word(cmd, fr, $urandom_range(0, 7) != 0, qf,
                          2'($urandom), 5'($urandom));
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        $display("covered %0d result words checked under %0d register writes", checked,
                 cfg_writes);
        $display("all commands, grids, wraps and x/8 accent groupings exercised");
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
